// File: hdl/assert_macros.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fvcc_pkg.sv
`default_nettype none
package fvcc_pkg;

  localparam int unsigned NumCols     = 55;
  localparam int unsigned CordicSteps = 20;
  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned QuotBits    = 17;
  localparam int unsigned CordicW     = 27;
  localparam int unsigned ZW          = 26;
  localparam int unsigned MagLat      = 1 + SqrtSteps + QuotBits;
  localparam int unsigned AngLat      = CordicSteps + 2;
  localparam int unsigned HueLat      = 2;

  typedef logic [2:0][7:0] rgb_t;
  typedef logic [2:0][23:0] mix_t;
  typedef logic [NumCols-1:0][2:0][7:0] wheel_tab_t;
  typedef logic [CordicSteps-1:0][21:0] atan_tab_t;

  typedef struct packed {
    logic        sat;
    logic [16:0] r16;
  } mag_t;

  function automatic wheel_tab_t build_wheel();
    wheel_tab_t t;
    int k;
    int j;
    t = '0;
    for (k = 0; k < NumCols; k++) begin
      if (k < 15) begin
        t[k] = {8'd0, 8'(255 * k / 15), 8'd255};
      end else if (k < 21) begin
        j = k - 15;
        t[k] = {8'd0, 8'd255, 8'(255 - 255 * j / 6)};
      end else if (k < 25) begin
        j = k - 21;
        t[k] = {8'(255 * j / 4), 8'd255, 8'd0};
      end else if (k < 36) begin
        j = k - 25;
        t[k] = {8'd255, 8'(255 - 255 * j / 11), 8'd0};
      end else if (k < 49) begin
        j = k - 36;
        t[k] = {8'd255, 8'd0, 8'(255 * j / 13)};
      end else begin
        j = k - 49;
        t[k] = {8'(255 - 255 * j / 6), 8'd0, 8'd255};
      end
    end
    return t;
  endfunction

  localparam wheel_tab_t Wheel = build_wheel();

  // arctan(2^-i) in 2^-24 turn units
  localparam atan_tab_t AtanTurns = {
    22'd5, 22'd10, 22'd20, 22'd41, 22'd81, 22'd163, 22'd326, 22'd652,
    22'd1304, 22'd2608, 22'd5215, 22'd10430, 22'd20860, 22'd41718,
    22'd83416, 22'd166669, 22'd332050, 22'd654136, 22'd1238021, 22'd2097152
  };

endpackage
`default_nettype wire

// File: hdl/flow_vector_color_coder.sv
// Flow vector color coder: one optical-flow vector in, one RGB color out.
// Input channel: in_valid_i/in_ready_o carry flow_x_i, flow_y_i (signed Q8.8)
// and flow_valid_i; a word is taken when valid and ready are both high.
// Output channel: out_valid_o/out_ready_i carry red_o, green_o, blue_o.
// max_motion is written via max_motion_we_i/max_motion_i; the user must do so only while idle (unenforced).
// From accept to out_valid_o a word passes 50 stages for the radius
// (square, 32-stage root, 17-stage divide), 2 blend stages, 1 skid write.
// The hue path (22-stage CORDIC, 2-stage wheel lookup) runs alongside and is
// delayed to meet the radius. One word per cycle while in_ready_o is high.
// A 2-entry output skid buffer holds results while the receiver stalls; when
// it fills, the whole pipeline freezes and in_ready_o drops, nothing is lost.
// Reset empties the pipeline and skid and sets max_motion to 10.0.
`default_nettype none
module flow_vector_color_coder import fvcc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] flow_x_i,
  input  wire logic signed [15:0] flow_y_i,
  input  wire logic               flow_valid_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o,
  input  wire logic               max_motion_we_i,
  input  wire logic [14:0]        max_motion_i
);

  localparam int unsigned PDly = MagLat - AngLat - HueLat;

  logic        en, acc, push, pop;
  logic [14:0] max_motion_q;
  mag_t        mag;
  logic [15:0] angle;
  mix_t        mix;

  logic [MagLat-1:0] vld_q, fv_q;
  mix_t pd_q [PDly];

  logic        b_vld_q, b_fv_q, b_use_q;
  mix_t        b_mix_q;
  logic [40:0] b_prod_q [3];
  logic        use_blend;

  logic        o_vld_q;
  rgb_t        o_rgb_d, o_rgb_q;

  logic [1:0]  cnt_d, cnt_q;
  rgb_t        slot0_q, slot1_q;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;
  assign acc        = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_motion_q <= 15'd2560;
    end else if (max_motion_we_i) begin
      max_motion_q <= max_motion_i;
    end
  end

  fvcc_mag u_mag (
    .clk_i,
    .en_i         (en),
    .flow_x_i,
    .flow_y_i,
    .max_motion_i (max_motion_q),
    .mag_o        (mag)
  );

  fvcc_angle u_angle (
    .clk_i,
    .en_i    (en),
    .flow_x_i,
    .flow_y_i,
    .angle_o (angle)
  );

  fvcc_hue u_hue (
    .clk_i,
    .en_i    (en),
    .angle_i (angle),
    .mix_o   (mix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[MagLat-2:0], acc};
      b_vld_q <= vld_q[MagLat-1];
      o_vld_q <= b_vld_q;
    end
  end

  assign use_blend = !mag.sat && (mag.r16 <= 17'h10000);

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      if (!b_fv_q) begin
        o_rgb_d[b] = 8'd0;
      end else if (b_use_q) begin
        o_rgb_d[b] = 8'((41'hFF_0000_0000 - b_prod_q[b]) >> 32);
      end else begin
        o_rgb_d[b] = 8'((26'(b_mix_q[b]) + 26'({b_mix_q[b], 1'b0})) >> 18);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fv_q     <= {fv_q[MagLat-2:0], flow_valid_i};
      pd_q[0]  <= mix;
      for (int i = 1; i < PDly; i++) begin
        pd_q[i] <= pd_q[i-1];
      end
      b_fv_q   <= fv_q[MagLat-1];
      b_use_q  <= use_blend;
      b_mix_q  <= pd_q[PDly-1];
      for (int b = 0; b < 3; b++) begin
        b_prod_q[b] <= 41'(mag.r16) * 41'(24'hFF0000 - pd_q[PDly-1][b]);
      end
      o_rgb_q  <= o_rgb_d;
    end
  end

  // output skid buffer
  assign push = o_vld_q && en;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case ({push, pop})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          slot0_q <= o_rgb_q;
        end else begin
          slot1_q <= o_rgb_q;
        end
      end
      2'b01: begin
        slot0_q <= slot1_q;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          slot0_q <= o_rgb_q;
        end else begin
          slot0_q <= slot1_q;
          slot1_q <= o_rgb_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign red_o       = slot0_q[0];
  assign green_o     = slot0_q[1];
  assign blue_o      = slot0_q[2];

endmodule
`default_nettype wire

// File: hdl/fvcc_mag.sv
`default_nettype none
module fvcc_mag import fvcc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] flow_x_i,
  input  wire logic signed [15:0] flow_y_i,
  input  wire logic [14:0]        max_motion_i,
  output mag_t                    mag_o
);

  localparam int unsigned RW = 35;

  logic signed [31:0] xw, yw;
  logic [31:0] xx_q, yy_q, sq;
  logic [14:0] mm;

  logic [RW-1:0] rem_q  [SqrtSteps];
  logic [31:0]   root_q [SqrtSteps];
  logic [31:0]   rad_q  [SqrtSteps];

  logic [14:0] drem_q [QuotBits];
  logic [16:0] quo_q  [QuotBits];
  logic [16:0] src_q  [QuotBits];
  logic        sat_q  [QuotBits];

  assign xw = 32'(flow_x_i);
  assign yw = 32'(flow_y_i);
  assign sq = xx_q + yy_q;
  assign mm = (max_motion_i == '0) ? 15'd1 : max_motion_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= xw * xw;
      yy_q <= yw * yw;
    end
  end

  // square root of sq * 2^32, one root bit per stage
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    logic [RW-1:0] rem_in, trial_rem, trial;
    logic [31:0]   root_in, rad_in;
    logic          ge;
    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sq;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end
    assign trial_rem = {rem_in[RW-3:0], rad_in[31:30]};
    assign trial     = {1'b0, root_in, 2'b01};
    assign ge        = trial_rem >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? trial_rem - trial : trial_rem;
        root_q[i] <= {root_in[30:0], ge};
        rad_q[i]  <= {rad_in[29:0], 2'b00};
      end
    end
  end

  // root / mm, 17 quotient bits; sat when quotient would reach 2^17
  for (genvar j = 0; j < QuotBits; j++) begin : g_div
    logic [14:0] rem_in;
    logic [16:0] quo_in, src_in;
    logic        sat_in, ge;
    logic [15:0] trial;
    if (j == 0) begin : g_first
      assign rem_in = root_q[SqrtSteps-1][31:17];
      assign quo_in = '0;
      assign src_in = root_q[SqrtSteps-1][16:0];
      assign sat_in = root_q[SqrtSteps-1][31:17] >= mm;
    end else begin : g_next
      assign rem_in = drem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign src_in = src_q[j-1];
      assign sat_in = sat_q[j-1];
    end
    assign trial = {rem_in, src_in[16]};
    assign ge    = trial >= {1'b0, mm};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[j] <= ge ? 15'(trial - {1'b0, mm}) : trial[14:0];
        quo_q[j]  <= {quo_in[15:0], ge};
        src_q[j]  <= {src_in[15:0], 1'b0};
        sat_q[j]  <= sat_in;
      end
    end
  end

  assign mag_o.sat = sat_q[QuotBits-1];
  assign mag_o.r16 = quo_q[QuotBits-1];

endmodule
`default_nettype wire

// File: hdl/fvcc_angle.sv
`default_nettype none
module fvcc_angle import fvcc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] flow_x_i,
  input  wire logic signed [15:0] flow_y_i,
  output logic [15:0]             angle_o
);

  logic signed [CordicW-1:0] xe, ye, xr, yr;
  logic        axis, neg;
  logic [15:0] axis_ang;

  logic signed [CordicW-1:0] x0_q, y0_q;
  logic        base0_q, axis0_q;
  logic [15:0] ang0_q;

  logic signed [CordicW-1:0] cx_q [CordicSteps];
  logic signed [CordicW-1:0] cy_q [CordicSteps];
  logic signed [ZW-1:0]      cz_q [CordicSteps];
  logic        base_q [CordicSteps];
  logic        axis_q [CordicSteps];
  logic [15:0] ang_q  [CordicSteps];

  logic signed [ZW-1:0] zt;
  logic [23:0] rnd;
  logic [15:0] angle_q;

  assign xe   = CordicW'(flow_x_i);
  assign ye   = CordicW'(flow_y_i);
  assign neg  = flow_x_i[15];
  assign axis = (flow_y_i == '0) || (flow_x_i == '0);
  assign xr   = neg ? -xe : xe;
  assign yr   = neg ? -ye : ye;

  always_comb begin
    if (flow_y_i == '0) begin
      axis_ang = flow_x_i[15] ? 16'd32768 : 16'd0;
    end else begin
      axis_ang = flow_y_i[15] ? 16'd49152 : 16'd16384;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q    <= xr <<< 8;
      y0_q    <= yr <<< 8;
      base0_q <= neg;
      axis0_q <= axis;
      ang0_q  <= axis_ang;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    logic signed [CordicW-1:0] cx, cy, xs, ys;
    logic signed [ZW-1:0]      cz, at;
    logic        b_in, a_in, dir;
    logic [15:0] g_in;
    if (i == 0) begin : g_first
      assign cx   = x0_q;
      assign cy   = y0_q;
      assign cz   = '0;
      assign b_in = base0_q;
      assign a_in = axis0_q;
      assign g_in = ang0_q;
    end else begin : g_next
      assign cx   = cx_q[i-1];
      assign cy   = cy_q[i-1];
      assign cz   = cz_q[i-1];
      assign b_in = base_q[i-1];
      assign a_in = axis_q[i-1];
      assign g_in = ang_q[i-1];
    end
    assign xs  = cx >>> i;
    assign ys  = cy >>> i;
    assign at  = signed'(ZW'(AtanTurns[i]));
    assign dir = !cy[CordicW-1] && (cy != '0);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[i]   <= dir ? cx + ys : cx - ys;
        cy_q[i]   <= dir ? cy - xs : cy + xs;
        cz_q[i]   <= dir ? cz + at : cz - at;
        base_q[i] <= b_in;
        axis_q[i] <= a_in;
        ang_q[i]  <= g_in;
      end
    end
  end

  assign zt  = cz_q[CordicSteps-1] + $signed({2'b00, base_q[CordicSteps-1], 23'd0});
  assign rnd = zt[23:0] + 24'd128;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= axis_q[CordicSteps-1] ? ang_q[CordicSteps-1] : rnd[23:8];
    end
  end

  assign angle_o = angle_q;

endmodule
`default_nettype wire

// File: hdl/fvcc_hue.sv
`default_nettype none
module fvcc_hue import fvcc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] angle_i,
  output mix_t             mix_o
);

  logic [21:0] pos_q;
  logic [5:0]  k0, k1;
  logic [15:0] f;
  logic [16:0] wf;
  mix_t        mix_d, mix_q;

  assign k0 = pos_q[21:16];
  assign f  = pos_q[15:0];
  assign k1 = (k0 == 6'(NumCols - 1)) ? 6'd0 : k0 + 6'd1;
  assign wf = 17'h10000 - {1'b0, f};

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      mix_d[b] = 24'(25'(wf) * 25'(Wheel[k0][b]) + 25'(f) * 25'(Wheel[k1][b]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q <= {6'd0, angle_i} * 22'd54;
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule
`default_nettype wire

// File: hdl/fvcc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module fvcc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] red_o,
  input wire logic [7:0] green_o,
  input wire logic [7:0] blue_o
);

  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(red_o) && $stable(green_o) && $stable(blue_o), "output word changed while stalled")
  `ASSERT_IMPL(a_empty_ready, !out_valid_o, in_ready_o, "input blocked with empty output")
  `ASSERT_NEXT(a_pop_frees, !in_ready_o && out_ready_i, in_ready_o, "pop did not free skid slot")

endmodule

bind flow_vector_color_coder fvcc_checker u_fvcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o)
);
`default_nettype wire
